/* hw/rtl/aazc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Armed alarm zone controller package
// Shared sizes, codes, configuration and result types, and a helper function.
// ----------------------------------------------------------------------------
package aazc_pkg;

  localparam int MAX_DIGITS  = 6;
  localparam int ZONE_COUNT  = 4;
  localparam int DIGITS_W    = 4 * MAX_DIGITS;
  localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);

  localparam int ZONE_W      = 3;
  localparam int SECS_W      = 7;
  localparam int PHASE_W     = 10;
  localparam int TIMER_W     = 16;
  localparam int EVENT_W     = 17;
  localparam int BAD_W       = 11;
  localparam int SECRET_W    = 24;
  localparam int LEN_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int MS_PER_SEC  = 1000;
  localparam int BAD_PIN_MS  = 1500;
  localparam int MAX_SECS    = 99;
  localparam int MAX_KEY_DIGIT = 9;

  typedef enum logic [3:0] {
    KEY_STAR = 4'd10,
    KEY_HASH = 4'd11
  } key_code_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRY_DELAY  = 3'd0,
    CFG_HOLD_LED     = 3'd1,
    CFG_SECRET       = 3'd2,
    CFG_SECRET_LEN   = 3'd3,
    CFG_IDLE_LIMIT   = 3'd4,
    CFG_FAST_BLINK   = 3'd5,
    CFG_SLOW_BLINK   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [SECS_W-1:0]   entry_delay_seconds;
    logic [SECS_W-1:0]   hold_led_seconds;
    logic [SECRET_W-1:0] secret_digits;
    logic [LEN_W-1:0]    secret_length;
    logic [TIMER_W-1:0]  entry_idle_limit_ms;
    logic [TIMER_W-1:0]  fast_blink_ms;
    logic [TIMER_W-1:0]  slow_blink_ms;
  } cfg_t;

  typedef struct packed {
    logic                  relay_on;
    logic [ZONE_COUNT-1:0] zone_leds;
    logic                  memory_led;
    logic                  event_led;
    logic                  notify_pulse;
    logic                  notify_is_test;
    logic                  disarm_now;
    logic                  keep_memory;
    logic [SECS_W-1:0]     seconds_left;
    logic [ZONE_W-1:0]     zone_number;
    logic [2:0]            digits_entered;
    logic                  bad_pin_shown;
  } result_t;

  // Zero counts as one second, anything above the display range saturates.
  function automatic logic [SECS_W-1:0] clamp_secs(input logic [SECS_W-1:0] v);
    logic [SECS_W-1:0] r;
    if (v == '0) begin
      r = SECS_W'(1);
    end else if (v > SECS_W'(MAX_SECS)) begin
      r = SECS_W'(MAX_SECS);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/aazc_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the seven setup registers, written one beat at a time by index.
// ----------------------------------------------------------------------------
module aazc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [aazc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [aazc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output aazc_pkg::cfg_t                  cfg_o
);
  import aazc_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.entry_delay_seconds <= SECS_W'(10);
      cfg_q.hold_led_seconds    <= SECS_W'(10);
      cfg_q.secret_digits       <= SECRET_W'(4660);
      cfg_q.secret_length       <= LEN_W'(4);
      cfg_q.entry_idle_limit_ms <= TIMER_W'(10000);
      cfg_q.fast_blink_ms       <= TIMER_W'(100);
      cfg_q.slow_blink_ms       <= TIMER_W'(500);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ENTRY_DELAY: cfg_q.entry_delay_seconds <= cfg_data_i[SECS_W-1:0];
        CFG_HOLD_LED:    cfg_q.hold_led_seconds    <= cfg_data_i[SECS_W-1:0];
        CFG_SECRET:      cfg_q.secret_digits       <= cfg_data_i[SECRET_W-1:0];
        CFG_SECRET_LEN:  cfg_q.secret_length       <= cfg_data_i[LEN_W-1:0];
        CFG_IDLE_LIMIT:  cfg_q.entry_idle_limit_ms <= cfg_data_i[TIMER_W-1:0];
        CFG_FAST_BLINK:  cfg_q.fast_blink_ms       <= cfg_data_i[TIMER_W-1:0];
        CFG_SLOW_BLINK:  cfg_q.slow_blink_ms       <= cfg_data_i[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/aazc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm controller core
// Input register, controller state and the one-millisecond update logic.
// ----------------------------------------------------------------------------
module aazc_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [aazc_pkg::ZONE_COUNT-1:0]  zone_switches_i,
  input  logic                             siren_enable_i,
  input  logic                             test_mode_i,
  input  logic                             key_valid_i,
  input  logic [3:0]                       key_code_i,
  input  aazc_pkg::cfg_t                   cfg_i,
  input  logic                             buf_full_i,
  output logic                             push_o,
  output aazc_pkg::result_t                result_o
);
  import aazc_pkg::*;

  // Input register.
  logic                  in_valid_q;
  logic [ZONE_COUNT-1:0] zones_q;
  logic                  siren_en_q;
  logic                  test_q;
  logic                  kv_q;
  logic [3:0]            kc_q;

  // Controller state.
  logic                  cd_q, cd_d;
  logic [ZONE_W-1:0]     tz_q, tz_d;
  logic [SECS_W-1:0]     sec_q, sec_d;
  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic [DIGITS_W-1:0]   dig_q, dig_d;
  logic [COUNT_W-1:0]    cnt_q, cnt_d;
  logic [TIMER_W-1:0]    idle_q, idle_d;
  logic                  siren_q, siren_d;
  logic                  relay_q, relay_d;
  logic                  alarm_q, alarm_d;
  logic [TIMER_W-1:0]    bt_q, bt_d;
  logic                  lvl_q, lvl_d;
  logic                  mled_q, mled_d;
  logic [EVENT_W-1:0]    ev_q, ev_d;
  logic [BAD_W-1:0]      bp_q, bp_d;
  logic                  disarmed_q, disarmed_d;

  logic                  advance;
  logic                  pin_ok;
  logic [DIGITS_W-1:0]   secret_ext;
  result_t               res;

  assign in_stall_o = in_valid_q && buf_full_i;
  assign advance    = in_valid_q && !buf_full_i;
  assign push_o     = advance;
  assign result_o   = res;
  assign secret_ext = DIGITS_W'(cfg_i.secret_digits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      zones_q    <= zone_switches_i;
      siren_en_q <= siren_enable_i;
      test_q     <= test_mode_i;
      kv_q       <= key_valid_i;
      kc_q       <= key_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_q       <= 1'b0;
      tz_q       <= '0;
      sec_q      <= '0;
      phase_q    <= '0;
      dig_q      <= '0;
      cnt_q      <= '0;
      idle_q     <= '0;
      siren_q    <= 1'b0;
      relay_q    <= 1'b0;
      alarm_q    <= 1'b0;
      bt_q       <= '0;
      lvl_q      <= 1'b0;
      mled_q     <= 1'b0;
      ev_q       <= '0;
      bp_q       <= '0;
      disarmed_q <= 1'b0;
    end else if (advance) begin
      cd_q       <= cd_d;
      tz_q       <= tz_d;
      sec_q      <= sec_d;
      phase_q    <= phase_d;
      dig_q      <= dig_d;
      cnt_q      <= cnt_d;
      idle_q     <= idle_d;
      siren_q    <= siren_d;
      relay_q    <= relay_d;
      alarm_q    <= alarm_d;
      bt_q       <= bt_d;
      lvl_q      <= lvl_d;
      mled_q     <= mled_d;
      ev_q       <= ev_d;
      bp_q       <= bp_d;
      disarmed_q <= disarmed_d;
    end
  end

  always_comb begin
    logic                  fresh;
    logic                  touched;
    logic                  found;
    logic                  disarm;
    logic                  keep;
    logic [ZONE_COUNT-1:0] zl;
    logic                  pulse;
    logic                  is_test;

    cd_d       = cd_q;
    tz_d       = tz_q;
    sec_d      = sec_q;
    phase_d    = phase_q;
    dig_d      = dig_q;
    cnt_d      = cnt_q;
    idle_d     = idle_q;
    siren_d    = siren_q;
    relay_d    = relay_q;
    alarm_d    = alarm_q;
    bt_d       = bt_q;
    lvl_d      = lvl_q;
    mled_d     = mled_q;
    ev_d       = ev_q;
    bp_d       = bp_q;
    disarmed_d = disarmed_q;
    res        = '0;
    fresh      = 1'b0;
    touched    = 1'b0;
    found      = 1'b0;
    disarm     = 1'b0;
    keep       = alarm_q | siren_q;
    zl         = '0;
    pulse      = 1'b0;
    is_test    = 1'b0;
    pin_ok     = 1'b0;

    if (!disarmed_q) begin
      if (ev_q != '0) ev_d = ev_q - EVENT_W'(1);
      if (bp_q != '0) bp_d = bp_q - BAD_W'(1);
      if (bt_q != '1) bt_d = bt_q + TIMER_W'(1);

      // The lowest active zone starts the entry countdown.
      if (!cd_q) begin
        for (int i = 0; i < ZONE_COUNT; i++) begin
          if (zones_q[i] && !found) begin
            found = 1'b1;
            tz_d  = ZONE_W'(i + 1);
          end
        end
        if (found) begin
          cd_d    = 1'b1;
          sec_d   = clamp_secs(cfg_i.entry_delay_seconds);
          phase_d = '0;
          dig_d   = '0;
          cnt_d   = '0;
          idle_d  = '0;
          fresh   = 1'b1;
          touched = 1'b1;
        end
      end

      // Entered digits above the entered count are always zero, so the
      // compare checks those nibbles against zero as well.
      pin_ok = (int'(cfg_i.secret_length) <= MAX_DIGITS) &&
               (int'(cnt_d) == int'(cfg_i.secret_length));
      for (int j = 0; j < MAX_DIGITS; j++) begin
        if (j < int'(cfg_i.secret_length)) begin
          if (dig_d[4*j +: 4] != secret_ext[4*j +: 4]) pin_ok = 1'b0;
        end else begin
          if (dig_d[4*j +: 4] != 4'd0) pin_ok = 1'b0;
        end
      end

      if (kv_q) begin
        priority if (kc_q <= 4'(MAX_KEY_DIGIT)) begin
          if (cnt_d < COUNT_W'(MAX_DIGITS)) begin
            dig_d = {dig_d[DIGITS_W-5:0], kc_q};
            cnt_d = cnt_d + COUNT_W'(1);
          end
          idle_d  = '0;
          touched = 1'b1;
        end else if (kc_q == KEY_HASH) begin
          dig_d   = '0;
          cnt_d   = '0;
          idle_d  = '0;
          touched = 1'b1;
        end else if (kc_q == KEY_STAR) begin
          if (pin_ok) begin
            disarm = 1'b1;
          end else begin
            bp_d  = BAD_W'(BAD_PIN_MS);
            dig_d = '0;
            cnt_d = '0;
          end
        end else begin
        end
      end

      if (disarm) begin
        relay_d         = 1'b0;
        siren_d         = 1'b0;
        alarm_d         = keep;
        cd_d            = 1'b0;
        disarmed_d      = 1'b1;
        res.disarm_now  = 1'b1;
        res.keep_memory = keep;
      end else begin
        if (!touched) begin
          if (cnt_d != '0 && idle_q >= cfg_i.entry_idle_limit_ms) begin
            dig_d = '0;
            cnt_d = '0;
          end
          if (idle_q != '1) idle_d = idle_q + TIMER_W'(1);
        end

        // Zone LED and memory LED share one blink timer and one level.
        if (cd_d) begin
          if (bt_d >= cfg_i.fast_blink_ms) begin
            bt_d  = '0;
            lvl_d = ~lvl_d;
          end
          for (int j = 0; j < ZONE_COUNT; j++) begin
            zl[j] = lvl_d && (tz_d == ZONE_W'(j + 1));
          end
        end
        if (alarm_q) begin
          if (bt_d >= cfg_i.slow_blink_ms) begin
            bt_d   = '0;
            lvl_d  = ~lvl_d;
            mled_d = lvl_d;
          end
        end else begin
          mled_d = siren_q;
        end

        // Second tick of the entry countdown.
        if (cd_d && !fresh) begin
          phase_d = phase_q + PHASE_W'(1);
          if (phase_d >= PHASE_W'(MS_PER_SEC)) begin
            phase_d = '0;
            if (sec_d != '0) sec_d = sec_d - SECS_W'(1);
            if (sec_d == '0) begin
              alarm_d = 1'b1;
              if (siren_en_q) begin
                relay_d = 1'b1;
                siren_d = 1'b1;
                pulse   = 1'b1;
                is_test = test_q;
              end else begin
                siren_d = 1'b0;
              end
              cd_d = 1'b0;
              ev_d = EVENT_W'(clamp_secs(cfg_i.hold_led_seconds)) *
                     EVENT_W'(MS_PER_SEC);
            end
          end
        end

        res.relay_on       = relay_d;
        res.zone_leds      = zl;
        res.memory_led     = mled_d;
        res.event_led      = (ev_d != '0);
        res.notify_pulse   = pulse;
        res.notify_is_test = is_test;
        res.seconds_left   = sec_d;
        res.zone_number    = tz_d;
        res.digits_entered = 3'(cnt_d);
        res.bad_pin_shown  = (bp_d != '0);
      end
    end
  end

endmodule

/* hw/rtl/aazc_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result buffer
// Output register with a skid stage, so a beat can be taken while the
// receiver stalls.
// ----------------------------------------------------------------------------
module aazc_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  aazc_pkg::result_t  push_data_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output aazc_pkg::result_t  out_data_o
);
  import aazc_pkg::*;

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    pop;

  assign pop         = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_q <= push_data_i;
      end else begin
        out_q <= push_data_i;
      end
    end
  end

endmodule

/* hw/rtl/armed_alarm_zone_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Armed alarm zone controller
// Armed-state controller of an intruder alarm, one input beat per millisecond.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one millisecond of zone switches, siren and
// test switches and an optional key press; each produces exactly one result
// beat. The input channel takes a beat when in_valid_i is high and in_stall_o
// is low; the result channel hands one over when out_valid_o is high and
// out_stall_i is low. Setup registers are written through the cfg port
// (always ready) by index; the user must write them only while the block is
// idle, as the block itself does not enforce it. The beat is captured in the
// input register, then the state update loads the result register.
// Throughput is one beat per cycle while the result buffer is not full.
// A stalled result waits in the output register while one more beat moves
// into a skid stage; only then does in_stall_o rise.
// Reset clears all controller state and loads the default setup (10 s entry
// delay and hold, PIN 1234). After a correct PIN disarms, every later beat
// returns all zeros until the next reset.
// ----------------------------------------------------------------------------
module armed_alarm_zone_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [aazc_pkg::ZONE_COUNT-1:0]  zone_switches_i,
  input  logic                             siren_enable_i,
  input  logic                             test_mode_i,
  input  logic                             key_valid_i,
  input  logic [3:0]                       key_code_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             relay_on_o,
  output logic [aazc_pkg::ZONE_COUNT-1:0]  zone_leds_o,
  output logic                             memory_led_o,
  output logic                             event_led_o,
  output logic                             notify_pulse_o,
  output logic                             notify_is_test_o,
  output logic                             disarm_now_o,
  output logic                             keep_memory_o,
  output logic [6:0]                       seconds_left_o,
  output logic [2:0]                       zone_number_o,
  output logic [2:0]                       digits_entered_o,
  output logic                             bad_pin_shown_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [aazc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [aazc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import aazc_pkg::*;

  cfg_t    cfg;
  result_t push_data;
  result_t out_data;
  logic    push;
  logic    buf_full;

  aazc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  aazc_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .zone_switches_i (zone_switches_i),
    .siren_enable_i  (siren_enable_i),
    .test_mode_i     (test_mode_i),
    .key_valid_i     (key_valid_i),
    .key_code_i      (key_code_i),
    .cfg_i           (cfg),
    .buf_full_i      (buf_full),
    .push_o          (push),
    .result_o        (push_data)
  );

  aazc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign relay_on_o       = out_data.relay_on;
  assign zone_leds_o      = out_data.zone_leds;
  assign memory_led_o     = out_data.memory_led;
  assign event_led_o      = out_data.event_led;
  assign notify_pulse_o   = out_data.notify_pulse;
  assign notify_is_test_o = out_data.notify_is_test;
  assign disarm_now_o     = out_data.disarm_now;
  assign keep_memory_o    = out_data.keep_memory;
  assign seconds_left_o   = out_data.seconds_left;
  assign zone_number_o    = out_data.zone_number;
  assign digits_entered_o = out_data.digits_entered;
  assign bad_pin_shown_o  = out_data.bad_pin_shown;

  // A test flag only ever rides along with a notify pulse.
  a_test_needs_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && notify_is_test_o |-> notify_pulse_o)
    else $error("notify_is_test without notify_pulse");

  // A disarm beat carries nothing but the disarm and keep flags.
  a_disarm_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && disarm_now_o |-> !relay_on_o && zone_leds_o == '0 &&
      !notify_pulse_o && digits_entered_o == 3'd0 && seconds_left_o == 7'd0)
    else $error("disarm beat carries other fields");

  // Keep-memory is only meaningful on a disarm beat.
  a_keep_needs_disarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && keep_memory_o |-> disarm_now_o)
    else $error("keep_memory without disarm_now");

  // The skid stage only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_full |-> out_valid_o)
    else $error("skid stage full while output register empty");

  // A beat that entered the result buffer shows up as a valid result.
  a_push_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_o)
    else $error("pushed beat lost");

endmodule
